[hw/rtl/v3n_pkg.sv]
// ----------------------------------------------------------------------------
// v3n_pkg: shared types and constants of the vector normalize unit.
// Widths of the square root and divider pipelines.
// ----------------------------------------------------------------------------
package v3n_pkg;

  localparam int CompW = 16;
  localparam int MagW  = 16;
  localparam int SqW   = 32;
  localparam int SumW  = 34;
  localparam int RadW  = 50;
  localparam int RootW = 25;
  localparam int NumW  = 38;
  localparam int QW    = 15;
  localparam logic [QW-1:0] UnitOne = QW'(16384);

  // Per-component data that travels along the pipeline.
  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
  } comp_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    logic  zero;
  } vec_t;

endpackage

[hw/rtl/vector3_normalize_unit.sv]
// ----------------------------------------------------------------------------
// vector3_normalize_unit: scales a 3-vector to unit length in Q2.14.
//
// Input transaction: x_in, y_in, z_in under in_valid/in_ready.
// Output transaction: x_unit, y_unit, z_unit, was_zero under out_valid/out_ready.
// One vector enters each cycle while in_ready is high. Stages: the squares,
// the sum, the bit-per-stage square root, the bit-per-stage dividers
// (three in parallel), and sign and output.
// The pipeline advances as a whole whenever its last stage is empty or
// taken; a stall from the receiver freezes every stage, so nothing is lost
// or repeated, and in_ready drops only while the last stage holds a
// transaction that is not taken.
// Reset clears all stage valid bits; data registers are not reset.
// A zero vector gives zero components and raises was_zero.
// ----------------------------------------------------------------------------
module vector3_normalize_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [15:0] x_in,
  input  logic signed [15:0] y_in,
  input  logic signed [15:0] z_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] x_unit,
  output logic signed [15:0] y_unit,
  output logic signed [15:0] z_unit,
  output logic        was_zero
);

  localparam int DivN = v3n_pkg::NumW;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: magnitudes and squares.
  logic                     v1;
  v3n_pkg::vec_t            vec1;
  logic [v3n_pkg::SqW-1:0]  sx, sy, sz;

  function automatic v3n_pkg::comp_t split(input logic signed [15:0] c);
    v3n_pkg::comp_t r;
    r.neg = c[15];
    r.mag = c[15] ? 16'(-c) : c;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec1.x    <= split(x_in);
      vec1.y    <= split(y_in);
      vec1.z    <= split(z_in);
      vec1.zero <= (x_in == 16'sd0) && (y_in == 16'sd0) && (z_in == 16'sd0);
      sx <= 32'(x_in * x_in);
      sy <= 32'(y_in * y_in);
      sz <= 32'(z_in * z_in);
    end
  end

  // Stage 2: sum of squares.
  logic                     v2;
  v3n_pkg::vec_t            vec2;
  logic [v3n_pkg::SumW-1:0] sum2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec2 <= vec1;
      sum2 <= 34'(sx) + 34'(sy) + 34'(sz);
    end
  end

  // Square root pipeline.
  logic                      v3;
  logic [v3n_pkg::RootW-1:0] root3;
  v3n_pkg::vec_t             vec3;

  v3n_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .sum       (sum2),
    .in_vec    (vec2),
    .out_valid (v3),
    .root      (root3),
    .out_vec   (vec3)
  );

  // A zero root only occurs for the zero vector; feed 1 to keep dividers sane.
  logic [v3n_pkg::RootW-1:0] dsor;
  assign dsor = (root3 == '0) ? v3n_pkg::RootW'(1) : root3;

  logic [v3n_pkg::QW-1:0] qx, qy, qz;

  v3n_div u_div_x (.clk(clk), .en(en), .mag(vec3.x.mag), .root(dsor), .quot(qx));
  v3n_div u_div_y (.clk(clk), .en(en), .mag(vec3.y.mag), .root(dsor), .quot(qy));
  v3n_div u_div_z (.clk(clk), .en(en), .mag(vec3.z.mag), .root(dsor), .quot(qz));

  // Valid and sign info delayed alongside the dividers.
  logic            vd   [DivN+1];
  v3n_pkg::vec_t   vecd [DivN+1];
  assign vd[0]   = v3;
  assign vecd[0] = vec3;

  for (genvar i = 0; i < DivN; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (rst) begin
        vd[i+1] <= 1'b0;
      end else if (en) begin
        vd[i+1] <= vd[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        vecd[i+1] <= vecd[i];
      end
    end
  end

  // Output stage: apply sign and the zero case.
  function automatic logic [15:0] signed_q(input logic neg, input logic zero,
                                           input logic [v3n_pkg::QW-1:0] q);
    logic [15:0] m;
    m = zero ? 16'd0 : {1'b0, q};
    return neg ? 16'(-m) : m;
  endfunction

  v3n_pkg::vec_t vo;
  assign vo = vecd[DivN];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vd[DivN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_unit   <= signed_q(vo.x.neg, vo.zero, qx);
      y_unit   <= signed_q(vo.y.neg, vo.zero, qy);
      z_unit   <= signed_q(vo.z.neg, vo.zero, qz);
      was_zero <= vo.zero;
    end
  end

  // A stalled output transaction holds its data.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(x_unit) && $stable(was_zero))
    else $error("output changed while stalled");

  // The x result never exceeds unit magnitude.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (x_unit <= 16'sd16384 && x_unit >= -16'sd16384))
    else $error("x_unit out of range");

  // A zero flag comes with zero components.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_zero |-> x_unit == 16'sd0 && y_unit == 16'sd0 && z_unit == 16'sd0)
    else $error("zero vector gave nonzero result");

endmodule

[hw/rtl/v3n_sqrt.sv]
// ----------------------------------------------------------------------------
// v3n_sqrt: pipelined integer square root, one result bit per stage.
// Takes the squared length and the vector info; appends 16 zero bits to the length.
// ----------------------------------------------------------------------------
module v3n_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [v3n_pkg::SumW-1:0]       sum,
  input  v3n_pkg::vec_t                  in_vec,
  output logic                           out_valid,
  output logic [v3n_pkg::RootW-1:0]      root,
  output v3n_pkg::vec_t                  out_vec
);

  localparam int N = v3n_pkg::RootW;
  localparam int RemW = v3n_pkg::RootW + 2;

  logic                         vld  [N+1];
  logic [v3n_pkg::RadW-1:0]     rad  [N+1];
  logic [RemW-1:0]              rem  [N+1];
  logic [N-1:0]                 res  [N+1];
  v3n_pkg::vec_t                vec  [N+1];

  assign vld[0] = in_valid;
  assign rad[0] = {sum, 16'd0};
  assign rem[0] = '0;
  assign res[0] = '0;
  assign vec[0] = in_vec;

  // Restoring root: bring down two radicand bits per stage.
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [RemW-1:0] trial;
    logic [RemW-1:0] cand;
    logic            ok;
    assign trial = {rem[i][RemW-3:0], rad[i][v3n_pkg::RadW-1 -: 2]};
    assign cand  = {res[i], 2'b01};
    assign ok    = trial >= cand;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rad[i+1] <= {rad[i][v3n_pkg::RadW-3:0], 2'b00};
        rem[i+1] <= ok ? trial - cand : trial;
        res[i+1] <= {res[i][N-2:0], ok};
        vec[i+1] <= vec[i];
      end
    end
  end

  assign out_valid = vld[N];
  assign root      = res[N];
  assign out_vec   = vec[N];

endmodule

[hw/rtl/v3n_div.sv]
// ----------------------------------------------------------------------------
// v3n_div: pipelined restoring divider for one component.
// Computes min(mag * 2^22 / root, 16384), one quotient bit per stage.
// ----------------------------------------------------------------------------
module v3n_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [v3n_pkg::MagW-1:0]      mag,
  input  logic [v3n_pkg::RootW-1:0]     root,
  output logic [v3n_pkg::QW-1:0]        quot
);

  localparam int NumW = v3n_pkg::NumW;
  localparam int RW   = v3n_pkg::RootW + 1;

  logic [NumW-1:0]               num [NumW+1];
  logic [RW-1:0]                 rem [NumW+1];
  logic [v3n_pkg::RootW-1:0]     dv  [NumW+1];
  logic                          big [NumW+1];
  logic [v3n_pkg::QW-1:0]        q   [NumW+1];

  assign num[0] = {mag, 22'd0};
  assign rem[0] = '0;
  assign dv[0]  = root;
  assign big[0] = 1'b0;
  assign q[0]   = '0;

  // One quotient bit per stage; any bit above the unit range sets a flag.
  for (genvar i = 0; i < NumW; i++) begin : g_stage
    logic [RW-1:0] trial;
    logic          ok;
    assign trial = {rem[i][RW-2:0], num[i][NumW-1]};
    assign ok    = trial >= {1'b0, dv[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        num[i+1] <= {num[i][NumW-2:0], 1'b0};
        rem[i+1] <= ok ? trial - {1'b0, dv[i]} : trial;
        dv[i+1]  <= dv[i];
        q[i+1]   <= {q[i][v3n_pkg::QW-2:0], ok};
        big[i+1] <= big[i] | (ok & (q[i][v3n_pkg::QW-1] | (i < NumW - v3n_pkg::QW)));
      end
    end
  end

  assign quot = (big[NumW] || q[NumW] > v3n_pkg::UnitOne) ? v3n_pkg::UnitOne : q[NumW];

endmodule

[tb/vector3_normalize_unit_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector3_normalize_unit_checker: scoreboard for the vector normalize unit.
// Watches both channels, computes the expected unit vector of each accepted
// input transaction and compares each result with the oldest expectation waiting.
// ----------------------------------------------------------------------------
module vector3_normalize_unit_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] x_in,
  input  logic signed [15:0] y_in,
  input  logic signed [15:0] z_in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] x_unit,
  input  logic signed [15:0] y_unit,
  input  logic signed [15:0] z_unit,
  input  logic               was_zero,
  output int                 fail_count,
  output int                 pending,
  output int                 results_seen,
  output int                 zero_seen
);

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               zero;
  } unit_vec_t;

  unit_vec_t unit_queue[$];

  // Integer square root, bit by bit, floor of the exact root.
  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] acc;
    logic [63:0] bitv;
    acc  = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= acc + bitv) begin
        n   = n - (acc + bitv);
        acc = (acc >> 1) + bitv;
      end else begin
        acc = acc >> 1;
      end
      bitv = bitv >> 2;
    end
    return acc;
  endfunction

  // Scale one component by 2^22 / length, truncated and saturated to unit.
  function automatic logic signed [15:0] scale_to_unit(input logic signed [15:0] c,
                                                       input logic [63:0] len);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (c < 0) ? 64'(-32'(c)) : 64'(c);
    q   = (mag << 22) / len;
    if (q > 64'd16384) q = 64'd16384;
    return (c < 0) ? -16'(q) : 16'(q);
  endfunction

  function automatic unit_vec_t normalize(input logic signed [15:0] x,
                                          input logic signed [15:0] y,
                                          input logic signed [15:0] z);
    unit_vec_t   res;
    logic [63:0] sq;
    logic [63:0] len;
    sq = 64'(32'(x) * 32'(x)) + 64'(32'(y) * 32'(y)) + 64'(32'(z) * 32'(z));
    if (sq == 0) begin
      res = '{x: '0, y: '0, z: '0, zero: 1'b1};
    end else begin
      len = floor_root(sq << 16);
      res = '{x: scale_to_unit(x, len), y: scale_to_unit(y, len),
              z: scale_to_unit(z, len), zero: 1'b0};
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  assign pending = unit_queue.size();

  // Record inputs and check outputs at each rising edge.
  always @(posedge clk) begin
    unit_vec_t want;
    if (rst) begin
      fail_count   = 0;
      results_seen <= 0;
      zero_seen    <= 0;
    end else begin
      if (in_valid && in_ready) unit_queue.push_back(normalize(x_in, y_in, z_in));
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (was_zero) zero_seen <= zero_seen + 1;
        if (unit_queue.size() == 0) begin
          $display("[%0t] result transaction with nothing expected", $time);
          fail_count++;
        end else begin
          want = unit_queue.pop_front();
          if (x_unit !== want.x) report_mismatch("x_unit", x_unit, want.x);
          if (y_unit !== want.y) report_mismatch("y_unit", y_unit, want.y);
          if (z_unit !== want.z) report_mismatch("z_unit", z_unit, want.z);
          if (was_zero !== want.zero) report_mismatch("was_zero", was_zero, want.zero);
        end
      end
    end
  end

endmodule

[tb/vector3_normalize_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector3_normalize_unit_tb: top testbench of the vector normalize unit.
// Drives directed and random vectors with random gaps on both channels and
// one long receiver stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module vector3_normalize_unit_tb;

  localparam int NumRandom  = 1300;
  localparam int IdleLimit  = 20000;
  localparam int Latency    = 66;
  localparam logic signed [15:0] MinVal = -16'sd32768;
  localparam logic signed [15:0] MaxVal = 16'sd32767;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] x_in = '0;
  logic signed [15:0] y_in = '0;
  logic signed [15:0] z_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] x_unit;
  logic signed [15:0] y_unit;
  logic signed [15:0] z_unit;
  logic was_zero;
  int fail_count;
  int pending;
  int results_seen;
  int zero_seen;
  int idle_cycles = 0;
  int sent = 0;
  bit stim_done = 1'b0;
  bit stall_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vector3_normalize_unit dut (.*);

  vector3_normalize_unit_checker checker_i (.*);

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Component values biased toward small, extreme and single-bit patterns.
  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, 7)) - 16'd3;
      1:       return $urandom_range(0, 1) ? MaxVal : MinVal;
      2:       return 16'(1 << $urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_vec(input logic signed [15:0] x, input logic signed [15:0] y,
                          input logic signed [15:0] z);
    int gap;
    x_in     <= x;
    y_in     <= y;
    z_in     <= z;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
    gap = gap_len();
    if (gap == 0 && sent % 7 == 0) gap = 1;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off early in the random part.
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!stall_done && sent > 200) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        stall_done = 1'b1;
      end
      out_ready <= 1'b1;
      n = $urandom_range(1, 30);
      repeat (n) @(negedge clk);
      n = gap_len();
      if (n != 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired");
      $display("vector3_normalize_unit_tb: errors");
      $finish;
    end
  end

  // Stimulus.
  initial begin
    int tail;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // Zero vector, extremes, single axes and the near-unit corner cases.
    send_vec(0, 0, 0);
    send_vec(MinVal, MinVal, MinVal);
    send_vec(MaxVal, MaxVal, MaxVal);
    send_vec(MaxVal, MinVal, MaxVal);
    send_vec(MinVal, 0, 0);
    send_vec(0, MinVal, 0);
    send_vec(0, 0, MinVal);
    send_vec(MaxVal, 0, 0);
    send_vec(0, MaxVal, 0);
    send_vec(0, 0, MaxVal);
    send_vec(1, 0, 0);
    send_vec(0, -1, 0);
    send_vec(0, 0, 1);
    send_vec(1, 1, 1);
    send_vec(-1, -1, -1);
    send_vec(3, 4, 0);
    send_vec(-2, 2, 1);
    send_vec(16'h5555, 16'sh2AAA, -16'sh5556);
    send_vec(MaxVal, 1, -1);
    send_vec(0, 0, 0);
    for (int i = 0; i < NumRandom; i++) send_vec(rand_comp(), rand_comp(), rand_comp());
    in_valid <= 1'b0;
    stim_done = 1'b1;
    while (pending != 0) @(posedge clk);
    tail = 0;
    while (tail < 2 * Latency) begin
      @(posedge clk);
      tail++;
    end
    $display("Sent %0d vectors; %0d results checked, %0d of them zero vectors.",
             sent, results_seen, zero_seen);
    $display("Run included a %0s receiver stall with the input held off.",
             stall_done ? "long" : "missing");
    if (fail_count == 0) $display("vector3_normalize_unit_tb: clean");
    else $display("vector3_normalize_unit_tb: errors");
    $finish;
  end

endmodule
